[hdl/cfir_pkg.sv]
// Shared types and constants for the complex FIR filter.
`default_nettype none
package cfir_pkg;

  localparam int MAX_TAPS     = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 16;
  localparam int COEF_FRAC    = 15;
  localparam int TAP_W        = $clog2(MAX_TAPS);
  localparam int CNT_W        = $clog2(MAX_TAPS + 1);
  localparam int TAPCFG_W     = 7;
  localparam int PROD_W       = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W        = PROD_W + TAP_W + 1;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int SAT_HI       = 2 ** (SAMPLE_WIDTH - 1) - 1;
  localparam int SAT_LO       = -(2 ** (SAMPLE_WIDTH - 1));
  localparam int ROUND_HALF   = 2 ** (COEF_FRAC - 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]          cfg_data_t;

  localparam cfg_idx_t REG_TAP_COUNT  = 2'd0;
  localparam cfg_idx_t REG_COEF_INDEX = 2'd1;
  localparam cfg_idx_t REG_COEF_VALUE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

endpackage
`default_nettype wire

[hdl/complex_fir_filter.sv]
// Complex-sample, real-tap direct-form FIR filter with one shared complex MAC.
//
// Input channel: in_valid_i / in_stall_o carrying sample_re_i, sample_im_i and
// channel_start_i. An item is taken when valid is high and stall is low.
// channel_start_i empties the history: taps reaching before it count as zero.
// Output channel: out_valid_o / out_stall_i carrying out_re_o, out_im_o and
// saturated_o, one result per input item, in order.
// Coefficients are loaded by writing coef_index then coef_value through the
// cfg port; tap_count selects how many taps are in use (above 64 means 64).
// Each item runs one tap per cycle through the shared multiply-accumulate,
// where the taps in use number min(tap_count, samples held since channel
// start); then the memory read, product and accumulate stages drain before
// the result is loaded into the output register. The next item is taken the
// cycle after the result is loaded. A stalled receiver holds one finished
// result while the next item is worked on.
// Reset clears the sequencer, history pointer, sample count and output valid;
// tap_count resets to 1. Coefficient memory holds nothing until written.
`default_nettype none
module complex_fir_filter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire cfir_pkg::sample_t  sample_re_i,
  input  wire cfir_pkg::sample_t  sample_im_i,
  input  wire logic               channel_start_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output cfir_pkg::sample_t       out_re_o,
  output cfir_pkg::sample_t       out_im_o,
  output logic                    saturated_o,
  input  wire logic               cfg_we_i,
  input  wire cfir_pkg::cfg_idx_t cfg_index_i,
  input  wire cfir_pkg::cfg_data_t cfg_data_i
);
  import cfir_pkg::*;

  state_e                 state_q, state_d;
  logic [TAPCFG_W-1:0]    tap_count_q;
  logic [TAP_W-1:0]       coef_index_q;
  logic [TAP_W-1:0]       hptr_q;
  logic [CNT_W-1:0]       seen_q, seen_base, seen_new;
  logic [CNT_W-1:0]       used_q, taps_lim, used_new;
  logic [CNT_W-1:0]       k_q;
  logic                   v1_q, v2_q;
  logic                   in_acc, issue, out_load;
  logic [TAP_W-1:0]       hist_addr;

  coef_t                  cmem [MAX_TAPS];
  logic [2*SAMPLE_WIDTH-1:0] hmem [MAX_TAPS];
  coef_t                  coef_rd_q;
  logic [2*SAMPLE_WIDTH-1:0] hist_rd_q;
  sample_t                hist_re, hist_im;

  logic signed [PROD_W-1:0] prod_re_q, prod_im_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
  logic signed [ACC_W-1:0]  rnd_re, rnd_im, q_re, q_im;
  logic                     hi_re, lo_re, hi_im, lo_im;
  sample_t                  res_re, res_im;

  logic                   out_valid_q;
  sample_t                out_re_q, out_im_q;
  logic                   sat_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign issue      = (state_q == ST_RUN) && (k_q < used_q);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign hist_addr  = hptr_q - k_q[TAP_W-1:0];

  // samples held after this item, and taps that reach real samples
  always_comb begin
    seen_base = channel_start_i ? '0 : seen_q;
    seen_new  = (seen_base < CNT_W'(MAX_TAPS)) ? seen_base + 1'b1 : seen_base;
    taps_lim  = (tap_count_q > TAPCFG_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                    : CNT_W'(tap_count_q);
    used_new  = (taps_lim < seen_new) ? taps_lim : seen_new;
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q  <= TAPCFG_W'(1);
      coef_index_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TAP_COUNT:  tap_count_q  <= cfg_data_i[TAPCFG_W-1:0];
        REG_COEF_INDEX: coef_index_q <= cfg_data_i[TAP_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficient memory
  always_ff @(posedge clk_i) begin
    if (cfg_we_i && cfg_index_i == REG_COEF_VALUE) begin
      cmem[coef_index_q] <= coef_t'(cfg_data_i[COEF_WIDTH-1:0]);
    end
    if (issue) begin
      coef_rd_q <= cmem[k_q[TAP_W-1:0]];
    end
  end

  // history memory; reads only start the cycle after the write
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hmem[hptr_q] <= {sample_re_i, sample_im_i};
    end
    if (issue) begin
      hist_rd_q <= hmem[hist_addr];
    end
  end

  assign hist_re = sample_t'(hist_rd_q[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
  assign hist_im = sample_t'(hist_rd_q[SAMPLE_WIDTH-1:0]);

  // product stage
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_re_q <= PROD_W'(coef_rd_q) * PROD_W'(hist_re);
      prod_im_q <= PROD_W'(coef_rd_q) * PROD_W'(hist_im);
    end
  end

  // accumulator
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (v2_q) begin
      acc_re_q <= acc_re_q + ACC_W'(prod_re_q);
      acc_im_q <= acc_im_q + ACC_W'(prod_im_q);
    end
  end

  // round half up, drop fraction, clip
  always_comb begin
    rnd_re = acc_re_q + ACC_W'(ROUND_HALF);
    rnd_im = acc_im_q + ACC_W'(ROUND_HALF);
    q_re   = rnd_re >>> COEF_FRAC;
    q_im   = rnd_im >>> COEF_FRAC;
    hi_re  = q_re > ACC_W'(SAT_HI);
    lo_re  = q_re < ACC_W'(SAT_LO);
    hi_im  = q_im > ACC_W'(SAT_HI);
    lo_im  = q_im < ACC_W'(SAT_LO);
    res_re = hi_re ? sample_t'(SAT_HI) : lo_re ? sample_t'(SAT_LO)
                                              : q_re[SAMPLE_WIDTH-1:0];
    res_im = hi_im ? sample_t'(SAT_HI) : lo_im ? sample_t'(SAT_LO)
                                              : q_im[SAMPLE_WIDTH-1:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RUN;
      ST_RUN:  if (!issue && !v1_q && !v2_q) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hptr_q  <= '0;
      seen_q  <= '0;
      used_q  <= '0;
      k_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (in_acc) begin
        seen_q <= seen_new;
        used_q <= used_new;
        k_q    <= '0;
      end else if (issue) begin
        k_q <= k_q + 1'b1;
      end
      if (out_load) begin
        hptr_q <= hptr_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_re_q <= res_re;
      out_im_q <= res_im;
      sat_q    <= hi_re || lo_re || hi_im || lo_im;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign saturated_o = sat_q;

  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> k_q <= used_q)
    else $error("tap counter ran past tap limit");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !v1_q && !v2_q)
    else $error("MAC pipeline busy while idle");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == ST_IDLE)
    else $error("result not loaded on leaving done");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> seen_q <= CNT_W'(MAX_TAPS) && used_q <= seen_q)
    else $error("sample count out of range");

endmodule
`default_nettype wire

[dv/complex_fir_filter_tb.sv]
// Complex FIR filter testbench: table and random samples, checked by a predictor or typed results.
module complex_fir_filter_tb;
  import cfir_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int LONG_HOLD    = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int END_WAIT     = 100;

  // index past the register list, writes to it must do nothing
  localparam cfg_idx_t REG_SPARE = 2'd3;

  typedef struct packed {
    sample_t re;
    sample_t im;
    logic    sat;
  } filt_out_t;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_FILL,
    ROW_SAMPLE
  } row_kind_e;

  typedef struct {
    row_kind_e kind;
    cfg_idx_t  idx;
    cfg_data_t data;
    sample_t   re;
    sample_t   im;
    logic      cs;
    logic      typed;
    filt_out_t want;
  } stim_row_t;

  logic      clk_i           = 1'b0;
  logic      rst_ni          = 1'b0;
  logic      in_valid_i      = 1'b0;
  logic      in_stall_o;
  sample_t   sample_re_i     = '0;
  sample_t   sample_im_i     = '0;
  logic      channel_start_i = 1'b0;
  logic      out_valid_o;
  logic      out_stall_i     = 1'b0;
  sample_t   out_re_o;
  sample_t   out_im_o;
  logic      saturated_o;
  logic      cfg_we_i        = 1'b0;
  cfg_idx_t  cfg_index_i     = '0;
  cfg_data_t cfg_data_i      = '0;

  // typed expectation travels with the item it belongs to
  logic      row_typed  = 1'b0;
  filt_out_t row_expect = '0;

  filt_out_t pending_outputs[$];
  stim_row_t stim_rows[$];
  int        errors        = 0;
  bit        calm          = 1'b0;
  int        hold_requests = 0;
  int        holds_done    = 0;

  // filter state as the predictor sees it
  coef_t   coef_mem [MAX_TAPS];
  sample_t hist_re  [MAX_TAPS];
  sample_t hist_im  [MAX_TAPS];
  int      wr_ptr   = 0;
  int      held     = 0;
  int      tap_cfg  = 1;
  int      coef_sel = 0;

  filt_out_t mon_got;
  filt_out_t mon_want;
  filt_out_t mon_pred;

  complex_fir_filter DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_re_i     (sample_re_i),
    .sample_im_i     (sample_im_i),
    .channel_start_i (channel_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_re_o        (out_re_o),
    .out_im_o        (out_im_o),
    .saturated_o     (saturated_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic sample_t round_sat(input longint acc, inout logic clip);
    longint q;
    q = (acc + ROUND_HALF) >>> COEF_FRAC;
    if (q > SAT_HI) begin
      clip = 1'b1;
      return sample_t'(SAT_HI);
    end
    if (q < SAT_LO) begin
      clip = 1'b1;
      return sample_t'(SAT_LO);
    end
    return sample_t'(q);
  endfunction

  function automatic filt_out_t filter_step(sample_t re, sample_t im, logic cs);
    filt_out_t res;
    longint    acc_re;
    longint    acc_im;
    int        taps;
    int        used;
    int        idx;
    logic      clip;
    acc_re = 0;
    acc_im = 0;
    clip   = 1'b0;
    if (cs) held = 0;
    hist_re[wr_ptr] = re;
    hist_im[wr_ptr] = im;
    if (held < MAX_TAPS) held++;
    taps = (tap_cfg > MAX_TAPS) ? MAX_TAPS : tap_cfg;
    used = (taps < held) ? taps : held;
    for (int k = 0; k < used; k++) begin
      idx = (wr_ptr + MAX_TAPS - k) % MAX_TAPS;
      acc_re += longint'(coef_mem[k]) * longint'(hist_re[idx]);
      acc_im += longint'(coef_mem[k]) * longint'(hist_im[idx]);
    end
    wr_ptr  = (wr_ptr + 1) % MAX_TAPS;
    res.re  = round_sat(acc_re, clip);
    res.im  = round_sat(acc_im, clip);
    res.sat = clip;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TAPCFG_W-1:0] pick_taps();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 55) return TAPCFG_W'($urandom_range(1, 8));
    if (r < 80) return TAPCFG_W'($urandom_range(9, 32));
    if (r < 92) return TAPCFG_W'($urandom_range(33, 64));
    return TAPCFG_W'($urandom_range(65, 127));
  endfunction

  function automatic sample_t rand_sample(int style);
    int r;
    case (style)
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(0, 511) - 256);
      default: begin
        r = $urandom_range(0, 3);
        if (r == 0) return sample_t'(SAT_HI);
        if (r == 1) return sample_t'(SAT_LO);
        return sample_t'($urandom);
      end
    endcase
  endfunction

  function automatic coef_t rand_coef(int style);
    int r;
    case (style)
      0: return coef_t'($urandom);
      1: return coef_t'($urandom_range(0, 4095) - 2048);
      default: begin
        r = $urandom_range(0, 3);
        if (r == 0) return coef_t'(16'h7FFF);
        if (r == 1) return coef_t'(16'h8000);
        if (r == 2) return '0;
        return coef_t'($urandom);
      end
    endcase
  endfunction

  function automatic void add_reg(cfg_idx_t idx, cfg_data_t data);
    stim_row_t row;
    row       = '{ROW_REG, '0, '0, '0, '0, 1'b0, 1'b0, '0};
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.data  = data;
    stim_rows = {stim_rows, row};
  endfunction

  function automatic void add_fill(cfg_data_t data);
    stim_row_t row;
    row       = '{ROW_FILL, '0, '0, '0, '0, 1'b0, 1'b0, '0};
    row.kind  = ROW_FILL;
    row.data  = data;
    stim_rows = {stim_rows, row};
  endfunction

  function automatic void add_smp(int re, int im, logic cs, logic typed,
                                  int er, int ei, logic es);
    stim_row_t row;
    row       = '{ROW_SAMPLE, '0, '0, '0, '0, 1'b0, 1'b0, '0};
    row.kind  = ROW_SAMPLE;
    row.re    = sample_t'(re);
    row.im    = sample_t'(im);
    row.cs    = cs;
    row.typed = typed;
    row.want  = {sample_t'(er), sample_t'(ei), es};
    stim_rows = {stim_rows, row};
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_outputs.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_sample(sample_t re, sample_t im, logic cs, logic typed,
                             filt_out_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_re_i     <= re;
    sample_im_i     <= im;
    channel_start_i <= cs;
    row_typed       <= typed;
    row_expect      <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Register mirror, prediction on input accept, check on output accept.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TAP_COUNT:  tap_cfg = int'(cfg_data_i[TAPCFG_W-1:0]);
          REG_COEF_INDEX: coef_sel = int'(cfg_data_i[TAP_W-1:0]);
          REG_COEF_VALUE: if (coef_sel < MAX_TAPS) coef_mem[coef_sel] = coef_t'(cfg_data_i);
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        mon_got = {out_re_o, out_im_o, saturated_o};
        if (pending_outputs.size() == 0) begin
          errors++;
          $display("%0t: unexpected output re %0d im %0d sat %0b", $time,
                   $signed(mon_got.re), $signed(mon_got.im), mon_got.sat);
        end else begin
          mon_want = pending_outputs.pop_front();
          if (mon_got.re !== mon_want.re) begin
            errors++;
            $display("%0t: out_re expected %0d, got %0d", $time,
                     $signed(mon_want.re), $signed(mon_got.re));
          end
          if (mon_got.im !== mon_want.im) begin
            errors++;
            $display("%0t: out_im expected %0d, got %0d", $time,
                     $signed(mon_want.im), $signed(mon_got.im));
          end
          if (mon_got.sat !== mon_want.sat) begin
            errors++;
            $display("%0t: saturated expected %0b, got %0b", $time,
                     mon_want.sat, mon_got.sat);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        mon_pred = filter_step(sample_re_i, sample_im_i, channel_start_i);
        if (row_typed) mon_pred = row_expect;
        pending_outputs = {pending_outputs, mon_pred};
      end
    end
  end

  initial begin : receiver
    int n;
    @(posedge clk_i);
    forever begin
      if (holds_done != hold_requests) begin
        // long hold-off: the filter fills and stalls its input
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("** complex_fir_filter: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        random_items;
    int        phase;
    int        nitems;
    int        nload;
    int        sstyle;
    int        cstyle;
    bit        full;
    logic      cs;
    cfg_data_t d;

    random_items = 0;
    phase        = 0;

    // tap count is 1 after reset, so only entry 0 is read until the fill
    add_reg(REG_COEF_INDEX, 16'h0000);
    add_reg(REG_COEF_VALUE, 16'h8000);
    // no channel start yet: history treated as empty
    add_smp( 32767, -32768, 1'b0, 1'b1, -32767,  32767, 1'b1);
    add_smp(-32768,  32767, 1'b1, 1'b1,  32767, -32767, 1'b1);
    add_smp(     0,      1, 1'b0, 1'b1,      0,     -1, 1'b0);
    add_smp( 16384, -16384, 1'b0, 1'b1, -16384,  16384, 1'b0);
    add_reg(REG_TAP_COUNT, 16'h0000);
    add_smp( 32767,  32767, 1'b0, 1'b1, 0, 0, 1'b0);
    add_smp(-32768, -32768, 1'b1, 1'b1, 0, 0, 1'b0);
    add_reg(REG_SPARE, 16'hFFFF);
    add_smp(  1234,  -4321, 1'b0, 1'b1, 0, 0, 1'b0);
    // c[0] = 0.5: halves round up
    add_reg(REG_TAP_COUNT, 16'h0001);
    add_reg(REG_COEF_VALUE, 16'h4000);
    add_smp(1, -1, 1'b0, 1'b1, 1,  0, 1'b0);
    add_smp(3, -3, 1'b0, 1'b1, 2, -1, 1'b0);
    add_fill(16'h8000);
    add_reg(REG_TAP_COUNT, 16'h0002);
    add_smp(-32768, 32767, 1'b1, 1'b1, 32767, -32767, 1'b1);
    add_smp(-32768, 32767, 1'b0, 1'b1, 32767, -32768, 1'b1);
    add_smp(   100,  -100, 1'b1, 1'b0, 0, 0, 1'b0);
    add_fill(16'h7FFF);
    // 127 taps saturate to the maximum
    add_reg(REG_TAP_COUNT, 16'hFFFF);
    add_smp( 32767, -32768, 1'b1, 1'b0, 0, 0, 1'b0);
    add_smp( 32767, -32768, 1'b0, 1'b0, 0, 0, 1'b0);
    add_smp(-32768,  32767, 1'b0, 1'b0, 0, 0, 1'b0);
    add_reg(REG_TAP_COUNT, 16'h0040);
    add_smp( 12345, -23456, 1'b0, 1'b0, 0, 0, 1'b0);
    add_reg(REG_TAP_COUNT, 16'h0041);
    add_smp(-54, 77, 1'b0, 1'b0, 0, 0, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[r]) begin
      row = stim_rows[r];
      case (row.kind)
        ROW_REG: write_reg(row.idx, row.data);
        ROW_FILL: begin
          for (int i = 0; i < MAX_TAPS; i++) begin
            write_reg(REG_COEF_INDEX, cfg_data_t'(i));
            write_reg(REG_COEF_VALUE, row.data);
          end
        end
        default: send_sample(row.re, row.im, row.cs, row.typed, row.want);
      endcase
    end

    while (random_items < RANDOM_ITEMS) begin
      phase++;
      calm = 1'b0;
      d = cfg_data_t'($urandom);
      d[TAPCFG_W-1:0] = pick_taps();
      write_reg(REG_TAP_COUNT, d);

      cstyle = $urandom_range(0, 2);
      full   = ($urandom_range(0, 3) == 0);
      nload  = full ? MAX_TAPS : int'($urandom_range(1, 8));
      for (int i = 0; i < nload; i++) begin
        d = cfg_data_t'($urandom);
        d[TAP_W-1:0] = full ? TAP_W'(i) : TAP_W'($urandom_range(0, MAX_TAPS - 1));
        write_reg(REG_COEF_INDEX, d);
        write_reg(REG_COEF_VALUE, cfg_data_t'(rand_coef(cstyle)));
      end
      if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, cfg_data_t'($urandom));

      calm = ($urandom_range(0, 5) == 0);
      if (phase == 2 || phase == 9) hold_requests++;

      nitems = $urandom_range(20, 120);
      sstyle = $urandom_range(0, 2);
      for (int j = 0; j < nitems; j++) begin
        if (j == 0)
          cs = ($urandom_range(0, 9) < 7);
        else
          cs = ($urandom_range(0, 39) == 0);
        send_sample(rand_sample(sstyle), rand_sample(sstyle), cs, 1'b0, '0);
        random_items++;
        if ($urandom_range(0, 149) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (END_WAIT) @(posedge clk_i);
    if (pending_outputs.size() != 0)
      $display("%0t: %0d expected outputs never arrived", $time, pending_outputs.size());
    if (errors == 0 && pending_outputs.size() == 0)
      $display("** complex_fir_filter: PASSED **");
    else
      $display("** complex_fir_filter: FAILED **");
    $finish;
  end

endmodule

[files.f]
hdl/cfir_pkg.sv
hdl/complex_fir_filter.sv
dv/complex_fir_filter_tb.sv
